// ===== hdl/stl_pkg.sv =====
`default_nettype none
package stl_pkg;

  localparam int COORD_BITS  = 12;
  localparam int MAX_WINDOWS = 64;
  localparam int FRAC_BITS   = 8;
  localparam int COUNT_BITS  = 7;
  localparam int DATA_BITS   = 32;
  localparam int ADDR_BITS   = 5;
  localparam int CNT_BITS    = $clog2(MAX_WINDOWS + 1);
  localparam int IDX_BITS    = $clog2(MAX_WINDOWS + 4);
  localparam int PROD_BITS   = FRAC_BITS + COORD_BITS;

  localparam logic [COORD_BITS-1:0] C_ONE = COORD_BITS'(1);

  typedef enum logic [2:0] {
    REG_AREA_LEFT       = 3'd0,
    REG_AREA_TOP        = 3'd1,
    REG_AREA_WIDTH      = 3'd2,
    REG_AREA_HEIGHT     = 3'd3,
    REG_MASTER_FRACTION = 3'd4,
    REG_SPIRAL_MODE     = 3'd5,
    REG_WINDOW_COUNT    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic start_pass;
    logic hidden;
  } in_word_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] tile_left;
    logic [COORD_BITS-1:0] tile_top;
    logic [COORD_BITS-1:0] tile_width;
    logic [COORD_BITS-1:0] tile_height;
  } out_word_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] area_left;
    logic [COORD_BITS-1:0] area_top;
    logic [COORD_BITS-1:0] area_height;
    logic [COORD_BITS-1:0] start_width;
    logic [COORD_BITS-1:0] start_rest;
    logic                  spiral_mode;
    logic [CNT_BITS-1:0]   win_n;
  } cfg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] cur_left;
    logic [COORD_BITS-1:0] cur_top;
    logic [COORD_BITS-1:0] cur_width;
    logic [COORD_BITS-1:0] cur_height;
    logic [COORD_BITS-1:0] rest_width;
    logic [COORD_BITS-1:0] rest_height;
    logic [IDX_BITS-1:0]   window_index;
  } st_t;

endpackage
`default_nettype wire

// ===== hdl/spiral_tile_layout.sv =====
`default_nettype none
// Fibonacci tiling engine: every accepted word stands for one window in list order, and
// each visible window yields one word with its rectangle. One word is taken per clock
// while in_stall is low; it waits in the input register while stl_tiler computes its
// rectangle, which the result register takes when the word fires. A hidden word gives no
// result and passes even while a result waits; a visible word stays in the input register
// until the result register is free or being emptied. Configuration goes through the APB
// port; the user writes it only while no word is in flight (the block does not enforce it).
module spiral_tile_layout (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire stl_pkg::in_word_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output stl_pkg::out_word_t                 out_data,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [stl_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [stl_pkg::DATA_BITS-1:0] pwdata,
  output logic      [stl_pkg::DATA_BITS-1:0] prdata,
  output logic                               pready
);

  stl_pkg::cfg_t      cfg;
  stl_pkg::in_word_t  item_r;
  stl_pkg::out_word_t tile, out_data_r;
  logic               in_vld_r, out_valid_r;
  logic               fire, accept, emit;

  stl_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  stl_tiler u_tiler (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (fire),
    .item  (item_r),
    .cfg   (cfg),
    .tile  (tile)
  );

  assign fire     = in_vld_r && (item_r.hidden || !out_valid_r || !out_stall);
  assign emit     = fire && !item_r.hidden;
  assign in_stall = in_vld_r && !fire;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        in_vld_r <= 1'b1;
      end else if (fire) begin
        in_vld_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (emit) begin
      out_data_r <= tile;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r)
    else $error("input stalled with an empty input register");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("visible window produced no result");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fire && !item_r.hidden))
    else $error("result appeared without a visible window");

  a_hidden_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item_r.hidden && out_valid_r && out_stall) |=> $stable(out_data_r))
    else $error("hidden window disturbed a waiting result");
`endif

endmodule
`default_nettype wire

// ===== hdl/stl_cfg.sv =====
`default_nettype none
module stl_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [stl_pkg::ADDR_BITS-1:0]   paddr,
  input  wire logic [stl_pkg::DATA_BITS-1:0]   pwdata,
  output logic      [stl_pkg::DATA_BITS-1:0]   prdata,
  output logic                                 pready,
  output stl_pkg::cfg_t                        cfg
);

  logic [stl_pkg::COORD_BITS-1:0] area_left_r, area_top_r, area_width_r, area_height_r;
  logic [stl_pkg::FRAC_BITS-1:0]  master_fraction_r;
  logic                           spiral_mode_r;
  logic [stl_pkg::COUNT_BITS-1:0] window_count_r;
  stl_pkg::cfg_t                  cfg_r, cfg_nxt;
  stl_pkg::reg_idx_t              idx;
  logic                           wr_en;
  logic [stl_pkg::PROD_BITS-1:0]  prod;
  logic [31:0]                    cnt_ext;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = stl_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_left_r       <= '0;
      area_top_r        <= '0;
      area_width_r      <= stl_pkg::COORD_BITS'(80);
      area_height_r     <= stl_pkg::COORD_BITS'(24);
      master_fraction_r <= stl_pkg::FRAC_BITS'(128);
      spiral_mode_r     <= 1'b0;
      window_count_r    <= '0;
    end else if (wr_en) begin
      case (idx)
        stl_pkg::REG_AREA_LEFT:       area_left_r       <= pwdata[stl_pkg::COORD_BITS-1:0];
        stl_pkg::REG_AREA_TOP:        area_top_r        <= pwdata[stl_pkg::COORD_BITS-1:0];
        stl_pkg::REG_AREA_WIDTH:      area_width_r      <= pwdata[stl_pkg::COORD_BITS-1:0];
        stl_pkg::REG_AREA_HEIGHT:     area_height_r     <= pwdata[stl_pkg::COORD_BITS-1:0];
        stl_pkg::REG_MASTER_FRACTION: master_fraction_r <= pwdata[stl_pkg::FRAC_BITS-1:0];
        stl_pkg::REG_SPIRAL_MODE:     spiral_mode_r     <= pwdata[0];
        stl_pkg::REG_WINDOW_COUNT:    window_count_r    <= pwdata[stl_pkg::COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      stl_pkg::REG_AREA_LEFT:       prdata = stl_pkg::DATA_BITS'(area_left_r);
      stl_pkg::REG_AREA_TOP:        prdata = stl_pkg::DATA_BITS'(area_top_r);
      stl_pkg::REG_AREA_WIDTH:      prdata = stl_pkg::DATA_BITS'(area_width_r);
      stl_pkg::REG_AREA_HEIGHT:     prdata = stl_pkg::DATA_BITS'(area_height_r);
      stl_pkg::REG_MASTER_FRACTION: prdata = stl_pkg::DATA_BITS'(master_fraction_r);
      stl_pkg::REG_SPIRAL_MODE:     prdata = stl_pkg::DATA_BITS'(spiral_mode_r);
      stl_pkg::REG_WINDOW_COUNT:    prdata = stl_pkg::DATA_BITS'(window_count_r);
      default:                      prdata = '0;
    endcase
  end

  // The starting rectangle of a pass is derived from the registers and held in cfg_r.
  always_comb begin
    prod    = stl_pkg::PROD_BITS'(master_fraction_r) * stl_pkg::PROD_BITS'(area_width_r);
    cnt_ext = 32'(window_count_r);
    cfg_nxt = '0;
    cfg_nxt.area_left   = area_left_r;
    cfg_nxt.area_top    = area_top_r;
    cfg_nxt.area_height = area_height_r;
    cfg_nxt.spiral_mode = spiral_mode_r;
    if (cnt_ext > 32'(stl_pkg::MAX_WINDOWS)) begin
      cfg_nxt.win_n = stl_pkg::CNT_BITS'(stl_pkg::MAX_WINDOWS);
    end else begin
      cfg_nxt.win_n = stl_pkg::CNT_BITS'(cnt_ext);
    end
    if (cfg_nxt.win_n == stl_pkg::CNT_BITS'(1)) begin
      cfg_nxt.start_width = area_width_r;
    end else begin
      cfg_nxt.start_width = prod[stl_pkg::PROD_BITS-1:stl_pkg::FRAC_BITS];
    end
    cfg_nxt.start_rest = area_width_r - cfg_nxt.start_width - stl_pkg::C_ONE;
  end

  always_ff @(posedge clk) begin
    cfg_r <= cfg_nxt;
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== hdl/stl_tiler.sv =====
`default_nettype none
module stl_tiler (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire stl_pkg::in_word_t item,
  input  wire stl_pkg::cfg_t     cfg,
  output stl_pkg::out_word_t     tile
);

  stl_pkg::st_t                   st_r, st_nxt, base;
  logic [stl_pkg::COORD_BITS-1:0] x, y, w, h, rw, rh;
  logic [stl_pkg::IDX_BITS:0]     i_inc;
  logic [1:0]                     phase;
  logic                           more;

  always_comb begin
    if (item.start_pass) begin
      base.cur_left     = cfg.area_left;
      base.cur_top      = cfg.area_top;
      base.cur_width    = cfg.start_width;
      base.cur_height   = cfg.area_height;
      base.rest_width   = cfg.start_rest;
      base.rest_height  = cfg.area_height;
      base.window_index = '0;
    end else begin
      base = st_r;
    end

    x  = base.cur_left;
    y  = base.cur_top;
    w  = base.cur_width;
    h  = base.cur_height;
    rw = base.rest_width;
    rh = base.rest_height;
    i_inc = (stl_pkg::IDX_BITS+1)'(base.window_index) + (stl_pkg::IDX_BITS+1)'(1);
    more  = i_inc < (stl_pkg::IDX_BITS+1)'(cfg.win_n);
    phase = cfg.spiral_mode ? base.window_index[1:0] : {1'b0, base.window_index[0]};

    unique case (phase)
      2'd0: begin
        if (base.window_index != '0) begin
          if (cfg.spiral_mode) begin
            h = rh;
            y = y - rh;
          end else begin
            y = y + h;
            h = rh;
          end
          if (more) begin
            w  = w >> 1;
            rw = rw - w - stl_pkg::C_ONE;
          end
        end
      end
      2'd1: begin
        x = x + w + stl_pkg::C_ONE;
        w = rw;
        if (more) begin
          h  = h >> 1;
          rh = rh - h;
        end
      end
      2'd2: begin
        y = y + h;
        h = rh;
        if (more) begin
          w  = w >> 1;
          rw = rw - w - stl_pkg::C_ONE;
          x  = x + rw + stl_pkg::C_ONE;
        end
      end
      2'd3: begin
        w = rw;
        x = x - rw - stl_pkg::C_ONE;
        if (more) begin
          h  = h >> 1;
          rh = rh - h;
          y  = y + rh;
        end
      end
    endcase

    if (i_inc >= (stl_pkg::IDX_BITS+1)'(stl_pkg::MAX_WINDOWS + 4)) begin
      i_inc = i_inc - (stl_pkg::IDX_BITS+1)'(4);
    end

    if (item.hidden) begin
      st_nxt = base;
    end else begin
      st_nxt.cur_left     = x;
      st_nxt.cur_top      = y;
      st_nxt.cur_width    = w;
      st_nxt.cur_height   = h;
      st_nxt.rest_width   = rw;
      st_nxt.rest_height  = rh;
      st_nxt.window_index = i_inc[stl_pkg::IDX_BITS-1:0];
    end

    tile.tile_left   = x;
    tile.tile_top    = y;
    tile.tile_width  = w;
    tile.tile_height = h;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (en) begin
      st_r <= st_nxt;
    end
  end

endmodule
`default_nettype wire
